>>> rtl/core/s2a_pkg.sv
// shared types, key codes and keymap tables for the scancode translator
`default_nettype none

package s2a_pkg;

  typedef logic [7:0] scancode_t;
  typedef logic [6:0] ascii_t;

  localparam scancode_t KEY_CAPS      = 8'h3A;
  localparam scancode_t KEY_LSHIFT    = 8'h2A;
  localparam scancode_t KEY_LSHIFT_UP = 8'hAA;
  localparam scancode_t KEY_RSHIFT    = 8'h36;
  localparam scancode_t KEY_RSHIFT_UP = 8'hB6;
  localparam scancode_t KEY_CTRL      = 8'h1D;
  localparam scancode_t KEY_CTRL_UP   = 8'h9D;
  localparam scancode_t KEY_L         = 8'h26;
  localparam scancode_t RELEASE_BIT   = 8'h80;

  localparam logic EVENT_CHAR  = 1'b0;
  localparam logic EVENT_CLEAR = 1'b1;

  // us layout, unshifted
  function automatic ascii_t keymap_plain(input logic [6:0] code);
    ascii_t ch;
    case (code)
      7'h02: ch = 7'h31; 7'h03: ch = 7'h32; 7'h04: ch = 7'h33; 7'h05: ch = 7'h34;
      7'h06: ch = 7'h35; 7'h07: ch = 7'h36; 7'h08: ch = 7'h37; 7'h09: ch = 7'h38;
      7'h0A: ch = 7'h39; 7'h0B: ch = 7'h30; 7'h0C: ch = 7'h2D; 7'h0D: ch = 7'h3D;
      7'h10: ch = 7'h71; 7'h11: ch = 7'h77; 7'h12: ch = 7'h65; 7'h13: ch = 7'h72;
      7'h14: ch = 7'h74; 7'h15: ch = 7'h79; 7'h16: ch = 7'h75; 7'h17: ch = 7'h69;
      7'h18: ch = 7'h6F; 7'h19: ch = 7'h70; 7'h1A: ch = 7'h5B; 7'h1B: ch = 7'h5D;
      7'h1E: ch = 7'h61; 7'h1F: ch = 7'h73; 7'h20: ch = 7'h64; 7'h21: ch = 7'h66;
      7'h22: ch = 7'h67; 7'h23: ch = 7'h68; 7'h24: ch = 7'h6A; 7'h25: ch = 7'h6B;
      7'h26: ch = 7'h6C; 7'h27: ch = 7'h3B; 7'h28: ch = 7'h27; 7'h29: ch = 7'h60;
      7'h2B: ch = 7'h5C; 7'h2C: ch = 7'h7A; 7'h2D: ch = 7'h78; 7'h2E: ch = 7'h63;
      7'h2F: ch = 7'h76; 7'h30: ch = 7'h62; 7'h31: ch = 7'h6E; 7'h32: ch = 7'h6D;
      7'h33: ch = 7'h2C; 7'h34: ch = 7'h2E; 7'h35: ch = 7'h2F; 7'h39: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  // us layout, shifted
  function automatic ascii_t keymap_shift(input logic [6:0] code);
    ascii_t ch;
    case (code)
      7'h02: ch = 7'h21; 7'h03: ch = 7'h40; 7'h04: ch = 7'h23; 7'h05: ch = 7'h24;
      7'h06: ch = 7'h25; 7'h07: ch = 7'h5E; 7'h08: ch = 7'h26; 7'h09: ch = 7'h2A;
      7'h0A: ch = 7'h28; 7'h0B: ch = 7'h29; 7'h0C: ch = 7'h5F; 7'h0D: ch = 7'h2B;
      7'h10: ch = 7'h51; 7'h11: ch = 7'h57; 7'h12: ch = 7'h45; 7'h13: ch = 7'h52;
      7'h14: ch = 7'h54; 7'h15: ch = 7'h59; 7'h16: ch = 7'h55; 7'h17: ch = 7'h49;
      7'h18: ch = 7'h4F; 7'h19: ch = 7'h50; 7'h1A: ch = 7'h7B; 7'h1B: ch = 7'h7D;
      7'h1E: ch = 7'h41; 7'h1F: ch = 7'h53; 7'h20: ch = 7'h44; 7'h21: ch = 7'h46;
      7'h22: ch = 7'h47; 7'h23: ch = 7'h48; 7'h24: ch = 7'h4A; 7'h25: ch = 7'h4B;
      7'h26: ch = 7'h4C; 7'h27: ch = 7'h3A; 7'h28: ch = 7'h22; 7'h29: ch = 7'h7E;
      7'h2B: ch = 7'h7C; 7'h2C: ch = 7'h5A; 7'h2D: ch = 7'h58; 7'h2E: ch = 7'h43;
      7'h2F: ch = 7'h56; 7'h30: ch = 7'h42; 7'h31: ch = 7'h4E; 7'h32: ch = 7'h4D;
      7'h33: ch = 7'h3C; 7'h34: ch = 7'h3E; 7'h35: ch = 7'h3F; 7'h39: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/scancode_to_ascii_translator.sv
// scancode set 1 to ascii translator with shift, control and caps lock tracking
//
//   channel | signals                          | role
//   in      | in_valid, in_ready, scancode     | one raw set-1 byte per request
//   out     | out_valid, out_ready, event_kind, ascii | zero or one result per byte
//
// one byte per cycle while the output is not stalled; a byte waits in the input register,
// where the modifier update and keymap lookup happen, then lands in the output register
// a result is registered into the output register when its byte leaves the input register
// a stalled output holds one result and the input register can still take one byte
// rst (synchronous) clears the modifier flags and both valid flags
`default_nettype none

module scancode_to_ascii_translator (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire s2a_pkg::scancode_t scancode,
  output logic              out_valid,
  input  wire               out_ready,
  output logic              event_kind,
  output s2a_pkg::ascii_t   ascii
);
  import s2a_pkg::*;

  scancode_t code;
  logic      code_valid;
  logic      shift_held, control_held, caps_locked;
  logic      shift_held_next, control_held_next, caps_locked_next;
  logic      has_result, kind_next, fire;
  ascii_t    ch, ascii_next;

  always_comb begin
    shift_held_next   = shift_held;
    control_held_next = control_held;
    caps_locked_next  = caps_locked;
    has_result        = 1'b0;
    kind_next         = EVENT_CHAR;
    ascii_next        = '0;
    ch                = '0;
    if ((code & RELEASE_BIT) != '0) begin
      if (code == KEY_LSHIFT_UP || code == KEY_RSHIFT_UP) shift_held_next = 1'b0;
      if (code == KEY_CTRL_UP) control_held_next = 1'b0;
    end else begin
      if (code == KEY_CAPS) caps_locked_next = ~caps_locked;
      if (code == KEY_CTRL) control_held_next = 1'b1;
      if (code == KEY_LSHIFT || code == KEY_RSHIFT) shift_held_next = 1'b1;
      if (control_held_next && code == KEY_L) begin
        has_result = 1'b1;
        kind_next  = EVENT_CLEAR;
      end else begin
        ch = shift_held_next ? keymap_shift(code[6:0]) : keymap_plain(code[6:0]);
        // caps lock flips case of letters only
        if (caps_locked_next && ((ch >= 7'h61 && ch <= 7'h7A) || (ch >= 7'h41 && ch <= 7'h5A)))
          ch = ch ^ 7'h20;
        has_result = (ch != '0);
        ascii_next = ch;
      end
    end
  end

  // the input register moves on unless its result has nowhere to go
  assign fire     = code_valid && (!has_result || !out_valid || out_ready);
  assign in_ready = !code_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid   <= 1'b0;
      out_valid    <= 1'b0;
      shift_held   <= 1'b0;
      control_held <= 1'b0;
      caps_locked  <= 1'b0;
    end else begin
      if (in_ready) code_valid <= in_valid;
      if (fire) begin
        shift_held   <= shift_held_next;
        control_held <= control_held_next;
        caps_locked  <= caps_locked_next;
      end
      if (fire && has_result) out_valid <= 1'b1;
      else if (out_ready)     out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) code <= scancode;
    if (fire && has_result) begin
      event_kind <= kind_next;
      ascii      <= ascii_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/s2a_checker.sv
// port-level checker for the scancode translator, bound to the top level
`default_nettype none

module s2a_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire s2a_pkg::scancode_t scancode,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire                 event_kind,
  input wire s2a_pkg::ascii_t ascii
);
  import s2a_pkg::*;

  // stalled input request holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(scancode))
    else $error("input request dropped or changed while stalled");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(ascii))
    else $error("result dropped or changed while stalled");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EVENT_CLEAR |-> ascii == '0)
    else $error("clear-screen result carries a character");

  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EVENT_CHAR |-> ascii != '0)
    else $error("character result with zero code");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind scancode_to_ascii_translator s2a_checker u_s2a_checker (.*);

`default_nettype wire

>>> tb/scancode_to_ascii_translator_tb.sv
// testbench for the scancode translator: directed key sequences, then random typing
module scancode_to_ascii_translator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import s2a_pkg::*;

  localparam scancode_t KEY_NONE      = 8'h00;
  localparam scancode_t KEY_1         = 8'h02;
  localparam scancode_t KEY_A         = 8'h1E;
  localparam scancode_t KEY_ENTER     = 8'h1C;
  localparam scancode_t KEY_BACKSLASH = 8'h2B;
  localparam scancode_t KEY_SLASH     = 8'h35;
  localparam scancode_t KEY_SPACE     = 8'h39;
  localparam scancode_t KEY_TOP_MAKE  = 8'h7F;
  localparam scancode_t KEY_TOP_BREAK = 8'hFF;
  localparam int        ITEMS_PER_SEG = 50;
  localparam int        RANDOM_SEGS   = 9;

  typedef struct packed {
    logic   kind;
    ascii_t ch;
  } key_event_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  scancode_t scancode = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  logic      event_kind;
  ascii_t    ascii;

  // us keymap rows for codes 0x00..0x39, tab marks a key with no character
  string plain_row = "\t\t1234567890-=\t\tqwertyuiop[]\t\tasdfghjkl;'\140\t\\zxcvbnm,./\t\t\t ";
  string shift_row = "\t\t!@#$%^&*()_+\t\tQWERTYUIOP{}\t\tASDFGHJKL:\"~\t|ZXCVBNM<>?\t\t\t ";

  bit         shift_down;
  bit         ctrl_down;
  bit         caps_on;
  bit         sender_idle = 1'b1;
  bit         receiver_idle = 1'b1;
  int         error_count;
  key_event_t pending_events[$];

  scancode_to_ascii_translator uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .scancode(scancode),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_kind(event_kind),
    .ascii(ascii)
  );

  always #2 clk = ~clk;

  // updates the modifier flags and tells whether this byte yields an event
  function automatic bit translate_code(input scancode_t code, output key_event_t ev);
    byte    raw;
    ascii_t ch;
    ev = '0;
    if ((code & RELEASE_BIT) != '0) begin
      if (code == KEY_LSHIFT_UP || code == KEY_RSHIFT_UP) shift_down = 1'b0;
      if (code == KEY_CTRL_UP) ctrl_down = 1'b0;
      return 1'b0;
    end
    if (code == KEY_CAPS) caps_on = !caps_on;
    if (code == KEY_CTRL) ctrl_down = 1'b1;
    if (code == KEY_LSHIFT || code == KEY_RSHIFT) shift_down = 1'b1;
    if (ctrl_down && code == KEY_L) begin
      ev.kind = EVENT_CLEAR;
      return 1'b1;
    end
    if (code > KEY_SPACE) raw = "\t";
    else raw = shift_down ? shift_row[code] : plain_row[code];
    ch = (raw == "\t") ? '0 : raw[6:0];
    // caps lock only swaps letter case
    if (caps_on && ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z"))) ch = ch ^ 7'h20;
    if (ch == '0) return 1'b0;
    ev.kind = EVENT_CHAR;
    ev.ch   = ch;
    return 1'b1;
  endfunction

  task automatic send_code(input scancode_t code);
    int         gap;
    key_event_t ev;
    gap = sender_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    scancode <= code;
    do @(posedge clk); while (!in_ready);
    if (translate_code(code, ev)) pending_events.push_back(ev);
  endtask

  task automatic test_plain_keys();
    send_code(KEY_NONE);
    send_code(KEY_TOP_MAKE);
    send_code(KEY_1);
    send_code(KEY_BACKSLASH);
    send_code(KEY_SPACE);
    send_code(KEY_ENTER);
  endtask

  task automatic test_shift_keys();
    send_code(KEY_LSHIFT);
    send_code(KEY_BACKSLASH);
    send_code(KEY_SLASH);
    send_code(KEY_LSHIFT_UP);
    send_code(KEY_RSHIFT);
    send_code(KEY_A);
    // an unknown release must leave shift held
    send_code(KEY_TOP_BREAK);
    send_code(KEY_1);
    send_code(KEY_RSHIFT_UP);
  endtask

  task automatic test_caps_lock();
    send_code(KEY_CAPS);
    send_code(KEY_A);
    send_code(KEY_LSHIFT);
    send_code(KEY_A);
    send_code(KEY_LSHIFT_UP);
    send_code(KEY_CAPS);
  endtask

  task automatic test_control_keys();
    send_code(KEY_CTRL);
    send_code(KEY_L);
    send_code(KEY_A);
    send_code(KEY_CTRL_UP);
    send_code(KEY_L);
  endtask

  task automatic test_release_codes();
    send_code(KEY_L | RELEASE_BIT);
    send_code(RELEASE_BIT);
  endtask

  task automatic test_random_typing();
    int        pick;
    scancode_t code;
    for (int seg = 0; seg < RANDOM_SEGS; seg++) begin
      sender_idle   = (seg % 3) != 0;
      receiver_idle = (seg % 4) != 1;
      for (int i = 0; i < ITEMS_PER_SEG; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          code = scancode_t'($urandom_range(KEY_1, KEY_SPACE));
        end else if (pick < 63) begin
          case ($urandom_range(0, 6))
            0: code = KEY_LSHIFT;
            1: code = KEY_RSHIFT;
            2: code = KEY_CTRL;
            3: code = KEY_CAPS;
            4: code = KEY_LSHIFT_UP;
            5: code = KEY_RSHIFT_UP;
            default: code = KEY_CTRL_UP;
          endcase
        end else if (pick < 73) begin
          code = KEY_L;
        end else if (pick < 83) begin
          code = scancode_t'($urandom_range(RELEASE_BIT, KEY_TOP_BREAK));
        end else begin
          code = scancode_t'($urandom_range(0, 255));
        end
        send_code(code);
      end
    end
  endtask

  initial begin : result_sink
    int         stall;
    key_event_t want;
    while (rst) @(posedge clk);
    forever begin
      stall = receiver_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_events.size() == 0) begin
        $error("result with no request pending: event_kind %0d ascii 0x%02h", event_kind, ascii);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind) begin
          $error("event_kind: expected %0d, actual %0d", want.kind, event_kind);
          error_count++;
        end
        if (ascii !== want.ch) begin
          $error("ascii: expected 0x%02h, actual 0x%02h", want.ch, ascii);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_plain_keys();
    test_shift_keys();
    test_caps_lock();
    test_control_keys();
    test_release_codes();
    test_random_typing();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
